// ----- hw/rtl/nec_ir_frame_transmitter_macros.svh -----
// Assertion macros used by the frame transmitter checker.
`ifndef NEC_IR_FRAME_TRANSMITTER_MACROS_SVH
`define NEC_IR_FRAME_TRANSMITTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock and idle during reset.
`define NIRFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock and idle during reset.
`define NIRFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/nirft_pkg.sv -----
// Shared types and constants for the NEC infrared frame transmitter.
`timescale 1ns / 1ps

package nirft_pkg;

    localparam int unsigned TICK_W     = 16;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned BITS_W     = 6;
    localparam int unsigned IDX_W      = 5;

    // Reset values of the timing registers (phase length in ticks minus one).
    localparam logic [TICK_W-1:0] LEADER_MARK_RST  = 16'd1237;
    localparam logic [TICK_W-1:0] LEADER_SPACE_RST = 16'd656;
    localparam logic [TICK_W-1:0] BURST_RST        = 16'd74;
    localparam logic [TICK_W-1:0] ZERO_SPACE_RST   = 16'd82;
    localparam logic [TICK_W-1:0] ONE_SPACE_RST    = 16'd249;

    // A code with any of these bits set is sent at full width.
    localparam logic [WORD_W-1:0] UPPER_HALF_MASK = 32'hFFFF0000;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LEADER_MARK  = 3'd0,
        REG_LEADER_SPACE = 3'd1,
        REG_BURST        = 3'd2,
        REG_ZERO_SPACE   = 3'd3,
        REG_ONE_SPACE    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] leader_mark;
        logic [TICK_W-1:0] leader_space;
        logic [TICK_W-1:0] burst;
        logic [TICK_W-1:0] zero_space;
        logic [TICK_W-1:0] one_space;
    } cfg_t;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_LEAD_MARK  = 5'b00010,
        PH_LEAD_SPACE = 5'b00100,
        PH_BURST      = 5'b01000,
        PH_BIT_SPACE  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic carrier_on;
        logic busy;
        logic frame_done;
    } result_t;

endpackage

// ----- hw/rtl/nirft_cfg_regs.sv -----
// Timing register file written through the configuration port.
`timescale 1ns / 1ps

module nirft_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [nirft_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [nirft_pkg::TICK_W-1:0]      cfg_wdata,
    output nirft_pkg::cfg_t                   cfg
);
    import nirft_pkg::*;

    cfg_t cfg_reg;

    // Indexes beyond the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.leader_mark  <= LEADER_MARK_RST;
            cfg_reg.leader_space <= LEADER_SPACE_RST;
            cfg_reg.burst        <= BURST_RST;
            cfg_reg.zero_space   <= ZERO_SPACE_RST;
            cfg_reg.one_space    <= ONE_SPACE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_LEADER_MARK:  cfg_reg.leader_mark  <= cfg_wdata;
                REG_LEADER_SPACE: cfg_reg.leader_space <= cfg_wdata;
                REG_BURST:        cfg_reg.burst        <= cfg_wdata;
                REG_ZERO_SPACE:   cfg_reg.zero_space   <= cfg_wdata;
                REG_ONE_SPACE:    cfg_reg.one_space    <= cfg_wdata;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/nirft_frame_seq.sv -----
// Frame sequencer: phase state, tick counter and bit shifter, one item per step.
`timescale 1ns / 1ps

module nirft_frame_seq #(
    parameter int unsigned CODE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic                          kind,
    input  logic [nirft_pkg::WORD_W-1:0]  code_word,
    input  nirft_pkg::cfg_t               cfg,
    output nirft_pkg::result_t            result
);
    import nirft_pkg::*;

    localparam int unsigned        LONG_SHIFT = WORD_W - CODE_WIDTH;
    localparam logic [WORD_W-1:0]  CODE_MASK  = WORD_W'((64'd1 << CODE_WIDTH) - 64'd1);
    localparam logic [IDX_W-1:0]   SHORT_LAST = IDX_W'(15);
    localparam logic [IDX_W-1:0]   LONG_LAST  = IDX_W'(CODE_WIDTH - 1);

    phase_t              phase_reg, phase_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [WORD_W-1:0]   shift_reg, shift_next;
    logic [BITS_W-1:0]   bits_reg, bits_next;
    logic [IDX_W-1:0]    last_reg, last_next;
    logic                cur_bit_reg, cur_bit_next;
    logic                final_reg, final_next;

    logic [TICK_W-1:0]   limit;
    logic [WORD_W-1:0]   code_masked;
    logic                code_long;
    logic [WORD_W-1:0]   load_word;
    logic [IDX_W-1:0]    load_last;
    logic [BITS_W-1:0]   bits_inc;

    // Code loading: a short code is the low half, aligned to the top of the shifter.
    assign code_masked = code_word & CODE_MASK;
    assign code_long   = |(code_masked & UPPER_HALF_MASK);
    assign load_word   = code_long ? (code_masked << LONG_SHIFT)
                                   : {code_masked[15:0], 16'h0000};
    assign load_last   = code_long ? LONG_LAST : SHORT_LAST;
    assign bits_inc    = bits_reg + 1'b1;

    // Length of the phase in force.
    always_comb
    begin
        case (phase_reg)
            PH_LEAD_MARK:  limit = cfg.leader_mark;
            PH_LEAD_SPACE: limit = cfg.leader_space;
            PH_BURST:      limit = cfg.burst;
            PH_BIT_SPACE:  limit = cur_bit_reg ? cfg.one_space : cfg.zero_space;
            default:       limit = '0;
        endcase
    end

    // Next state and result for the item at hand.
    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        shift_next   = shift_reg;
        bits_next    = bits_reg;
        last_next    = last_reg;
        cur_bit_next = cur_bit_reg;
        final_next   = final_reg;
        result       = '0;

        if (kind)
        begin
            // A start request is dropped while a frame is under way.
            if (phase_reg == PH_IDLE)
            begin
                shift_next   = load_word;
                last_next    = load_last;
                bits_next    = '0;
                cur_bit_next = 1'b0;
                final_next   = 1'b0;
                tick_next    = '0;
                phase_next   = PH_LEAD_MARK;
            end
            result.busy = 1'b1;
        end
        else if (phase_reg != PH_IDLE)
        begin
            result.busy       = 1'b1;
            result.carrier_on = phase_reg inside {PH_LEAD_MARK, PH_BURST};
            if (tick_reg < limit)
            begin
                tick_next = tick_reg + 1'b1;
            end
            else
            begin
                tick_next = '0;
                case (phase_reg)
                    PH_LEAD_MARK:
                    begin
                        phase_next = PH_LEAD_SPACE;
                    end
                    PH_LEAD_SPACE:
                    begin
                        bits_next  = '0;
                        final_next = 1'b0;
                        phase_next = PH_BURST;
                    end
                    PH_BURST:
                    begin
                        if (final_reg)
                        begin
                            phase_next        = PH_IDLE;
                            final_next        = 1'b0;
                            result.frame_done = 1'b1;
                        end
                        else
                        begin
                            cur_bit_next = shift_reg[WORD_W-1];
                            bits_next    = bits_inc;
                            if (bits_inc > BITS_W'(last_reg))
                            begin
                                final_next = 1'b1;
                            end
                            else
                            begin
                                shift_next = shift_reg << 1;
                            end
                            phase_next = PH_BIT_SPACE;
                        end
                    end
                    PH_BIT_SPACE:
                    begin
                        phase_next = PH_BURST;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // State moves on only when the item leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            shift_reg   <= '0;
            bits_reg    <= '0;
            last_reg    <= '0;
            cur_bit_reg <= 1'b0;
            final_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            shift_reg   <= shift_next;
            bits_reg    <= bits_next;
            last_reg    <= last_next;
            cur_bit_reg <= cur_bit_next;
            final_reg   <= final_next;
        end
    end

endmodule

// ----- hw/rtl/nec_ir_frame_transmitter.sv -----
// Top level of the NEC infrared frame transmitter.
`timescale 1ns / 1ps

// The input channel (in_valid, in_stall, kind, code_word) carries one beat per
// item: a time tick (kind 0) or a request to send code_word (kind 1).
// The output channel (out_valid, out_stall, carrier_on, busy_res, frame_done)
// returns exactly one beat for every input beat, in order.
// The user must write timing registers through cfg_wr_en, cfg_addr and cfg_wdata
// only while no item is in flight; the block does not enforce this. Unknown indexes are ignored.
// Each accepted beat is captured in an input register, the frame state is
// updated in a single pass, and the result lands in an output register.
// The block takes one beat per cycle while the output is not stalled; the phase,
// tick counter and shifter are updated in that pass between those two registers.
// When the receiver stalls, the result holds and the input register keeps one
// beat, after which in_stall rises until the output is taken.
// Reset clears the valid flags of both registers, loads the default timing values
// and returns the sequencer to idle; the block accepts beats once reset is released.
module nec_ir_frame_transmitter #(
    parameter int unsigned CODE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [nirft_pkg::WORD_W-1:0]      code_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              carrier_on,
    output logic                              busy_res,
    output logic                              frame_done,
    input  logic                              cfg_wr_en,
    input  logic [nirft_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [nirft_pkg::TICK_W-1:0]      cfg_wdata
);
    import nirft_pkg::*;

    cfg_t               cfg;
    result_t            seq_result;
    result_t            result_reg;
    logic               out_valid_reg;
    logic               in_valid_reg;
    logic               kind_reg;
    logic [WORD_W-1:0]  code_reg;
    logic               advance;
    logic               in_take;

    // The input register moves on whenever the output register is free or taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    nirft_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    nirft_frame_seq #(
        .CODE_WIDTH (CODE_WIDTH)
    ) u_frame_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (in_valid_reg && advance),
        .kind      (kind_reg),
        .code_word (code_reg),
        .cfg       (cfg),
        .result    (seq_result)
    );

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance || !in_valid_reg)
        begin
            in_valid_reg <= in_take;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg <= kind;
            code_reg <= code_word;
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            result_reg <= seq_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign carrier_on = result_reg.carrier_on;
    assign busy_res   = result_reg.busy;
    assign frame_done = result_reg.frame_done;

endmodule

// ----- hw/rtl/nirft_checker.sv -----
// Port-level checker for the frame transmitter and its bind.
`timescale 1ns / 1ps
`include "nec_ir_frame_transmitter_macros.svh"

module nirft_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_stall,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              carrier_on,
    input  logic                              busy_res,
    input  logic                              frame_done
);

    // A stalled result beat stays offered and unchanged.
    `NIRFT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(carrier_on) && $stable(busy_res) && $stable(frame_done), "stalled result beat changed")

    // The input side is never held off while the output register is empty.
    `NIRFT_ASSERT_NOW(a_no_needless_stall, clk, rst_n, !out_valid, !in_stall, "input stalled with output empty")

    // Carrier is only ever emitted inside a frame.
    `NIRFT_ASSERT_NOW(a_carrier_busy, clk, rst_n, out_valid && carrier_on, busy_res, "carrier without a frame")

    // A frame ends on the last tick of the closing burst, a carrier tick.
    `NIRFT_ASSERT_NOW(a_done_in_burst, clk, rst_n, out_valid && frame_done, busy_res && carrier_on, "frame end outside a burst")

endmodule

bind nec_ir_frame_transmitter nirft_checker u_nirft_checker (.*);
